// ===== sv/wss_pkg.sv =====
// ----------------------------------------------------------------------------
// Wake/sleep sequencer package
// Shared types, codes and defaults for the wake/sleep power sequencer.
// ----------------------------------------------------------------------------
package wss_pkg;

  localparam int unsigned CountW  = 4;
  localparam int unsigned HoldW   = 5;
  localparam int unsigned IdW     = 29;
  localparam int unsigned WakeIdW = 11;
  localparam int unsigned BitSelW = 8;
  localparam int unsigned DataW   = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 11;

  localparam int unsigned DefShutdownTicks = 10;
  localparam int unsigned DefCanHoldTicks  = 20;

  // Bit setting that lets any frame with the right identifier wake
  localparam logic [BitSelW-1:0] BIT_ANY = 8'd255;

  // Item kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PIN_TRIGGER_EN = 3'd0,
    REG_OUTPUT_EN      = 3'd1,
    REG_CAN_LISTEN_EN  = 3'd2,
    REG_WAKE_FRAME_ID  = 3'd3,
    REG_WAKE_BIT_SEL   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic                 pin_trigger_enabled;
    logic                 output_enabled;
    logic                 can_listen_enabled;
    logic [WakeIdW-1:0]   wake_frame_id;
    logic [BitSelW-1:0]   wake_bit_select;
  } cfg_t;

  typedef struct packed {
    logic                 kind;
    logic                 trigger_level;
    logic                 frame_hit;
  } item_t;

  typedef struct packed {
    logic awake;
    logic power_up_event;
    logic power_down_event;
    logic flush_and_cut;
    logic output_level;
  } res_t;

endpackage

// ===== sv/wss_frame_match.sv =====
// ----------------------------------------------------------------------------
// Wake frame matcher
// Decides whether a received CAN frame is a wake frame: identifier compare
// and selected payload bit, with the any-frame setting.
// ----------------------------------------------------------------------------
module wss_frame_match
  import wss_pkg::*;
(
  input  cfg_t             cfg,
  input  logic [IdW-1:0]   frame_id,
  input  logic [DataW-1:0] frame_data,
  output logic             hit
);

  logic id_match;
  logic bit_hit;

  // Compare the full identifier; anything above the configured width misses
  assign id_match = (frame_id == {{(IdW-WakeIdW){1'b0}}, cfg.wake_frame_id});

  // Pick the payload bit; settings 64 to 254 never match
  always_comb begin
    if (cfg.wake_bit_select == BIT_ANY) begin
      bit_hit = 1'b1;
    end else if (cfg.wake_bit_select inside {[8'd0:8'd63]}) begin
      bit_hit = frame_data[cfg.wake_bit_select[5:0]];
    end else begin
      bit_hit = 1'b0;
    end
  end

  assign hit = cfg.can_listen_enabled && id_match && bit_hit;

endmodule

// ===== sv/wss_seq_core.sv =====
// ----------------------------------------------------------------------------
// Sequencer core
// Holds the awake flag, shutdown countdown, CAN hold timer and output pin
// state, and works out one item's result and next state in a single pass.
// ----------------------------------------------------------------------------
module wss_seq_core
  import wss_pkg::*;
#(
  parameter int unsigned SHUTDOWN_TICKS = DefShutdownTicks,
  parameter int unsigned CAN_HOLD_TICKS = DefCanHoldTicks
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  advance,
  input  item_t item,
  output res_t  res
);

  localparam logic [CountW-1:0] ShutLoad = CountW'(SHUTDOWN_TICKS);
  localparam logic [HoldW-1:0]  HoldLoad = HoldW'(CAN_HOLD_TICKS);

  logic              awake_flag, awake_flag_next;
  logic [CountW-1:0] shutdown_countdown, shutdown_countdown_next;
  logic [HoldW-1:0]  can_hold_timer, can_hold_timer_next;
  logic              output_pin_state, output_pin_state_next;
  logic              ev_up, ev_down, flush;

  // Walk the item's steps in order on the current state
  always_comb begin
    awake_flag_next         = awake_flag;
    shutdown_countdown_next = shutdown_countdown;
    can_hold_timer_next     = can_hold_timer;
    output_pin_state_next   = output_pin_state;
    ev_up                   = 1'b0;
    ev_down                 = 1'b0;
    flush                   = 1'b0;

    if (item.kind == KIND_TICK) begin
      // Pin check: wake on high, sleep on low
      if (cfg.pin_trigger_enabled) begin
        if (item.trigger_level && !awake_flag_next) begin
          ev_up           = 1'b1;
          awake_flag_next = 1'b1;
          if (cfg.output_enabled) output_pin_state_next = 1'b1;
        end else if (!item.trigger_level && awake_flag_next) begin
          ev_down                 = 1'b1;
          awake_flag_next         = 1'b0;
          shutdown_countdown_next = ShutLoad;
        end
      end
      // Count down; expiry with output enabled flushes and cuts power
      if (shutdown_countdown_next != '0) begin
        shutdown_countdown_next = shutdown_countdown_next - 1'b1;
        if (shutdown_countdown_next == '0 && cfg.output_enabled) begin
          flush                 = 1'b1;
          output_pin_state_next = 1'b0;
        end
      end
      // Hold expiry puts the system to sleep
      if (cfg.can_listen_enabled) begin
        if (can_hold_timer == HoldW'(1) && awake_flag_next) begin
          ev_down                 = 1'b1;
          awake_flag_next         = 1'b0;
          shutdown_countdown_next = ShutLoad;
        end
        if (can_hold_timer != '0) can_hold_timer_next = can_hold_timer - 1'b1;
      end
    end else if (item.frame_hit) begin
      // Wake frame: wake and load the hold
      if (!awake_flag_next) begin
        ev_up           = 1'b1;
        awake_flag_next = 1'b1;
        if (cfg.output_enabled) output_pin_state_next = 1'b1;
      end
      can_hold_timer_next = HoldLoad;
    end
  end

  assign res.awake            = awake_flag_next;
  assign res.power_up_event   = ev_up;
  assign res.power_down_event = ev_down;
  assign res.flush_and_cut    = flush;
  assign res.output_level     = output_pin_state_next;

  // Commit state when the item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      awake_flag         <= 1'b1;
      shutdown_countdown <= '0;
      can_hold_timer     <= '0;
      output_pin_state   <= 1'b1;
    end else if (advance) begin
      awake_flag         <= awake_flag_next;
      shutdown_countdown <= shutdown_countdown_next;
      can_hold_timer     <= can_hold_timer_next;
      output_pin_state   <= output_pin_state_next;
    end
  end

endmodule

// ===== sv/wake_sleep_power_sequencer.sv =====
// ----------------------------------------------------------------------------
// Wake/sleep power sequencer
// Input register, sequencer core and result register for tick and CAN items.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per item: kind 0 is a
//   timer tick using trigger_level, kind 1 a received CAN frame using
//   frame_id and frame_data. Output channel (out_valid/out_ready) returns
//   exactly one result beat per input beat, in order.
//   Configuration is written through cfg_we/cfg_index/cfg_data, one register
//   per cycle; the user must write only while no item is in flight, as the
//   block does not enforce it. An accepted beat is registered in the input
//   register, passes the matcher and core, and enters the result register when
//   free. Throughput: one beat per cycle while out_ready is high; the state
//   update is a short flag and counter pass between input and result registers.
//   Stall: when out_ready is low the result holds; the input register still
//   drains into an empty result register, then in_ready drops.
//   Reset: rst (synchronous) empties both registers, sets the system awake
//   with power output on, clears both timers and restores register defaults.
// ----------------------------------------------------------------------------
module wake_sleep_power_sequencer
  import wss_pkg::*;
#(
  parameter int unsigned SHUTDOWN_TICKS = DefShutdownTicks,
  parameter int unsigned CAN_HOLD_TICKS = DefCanHoldTicks
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic               trigger_level,
  input  logic [IdW-1:0]     frame_id,
  input  logic [DataW-1:0]   frame_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               awake,
  output logic               power_up_event,
  output logic               power_down_event,
  output logic               flush_and_cut,
  output logic               output_level
);

  cfg_t             cfg;
  logic             s1_valid;
  logic             s1_kind;
  logic             s1_level;
  logic [IdW-1:0]   s1_id;
  logic [DataW-1:0] s1_data;
  logic             s1_hit;
  logic             s1_adv;
  item_t            s1_item;
  res_t             res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pin_trigger_enabled <= 1'b0;
      cfg.output_enabled      <= 1'b0;
      cfg.can_listen_enabled  <= 1'b0;
      cfg.wake_frame_id       <= '1;
      cfg.wake_bit_select     <= BIT_ANY;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_PIN_TRIGGER_EN: cfg.pin_trigger_enabled <= cfg_data[0];
        REG_OUTPUT_EN:      cfg.output_enabled      <= cfg_data[0];
        REG_CAN_LISTEN_EN:  cfg.can_listen_enabled  <= cfg_data[0];
        REG_WAKE_FRAME_ID:  cfg.wake_frame_id       <= cfg_data[WakeIdW-1:0];
        REG_WAKE_BIT_SEL:   cfg.wake_bit_select     <= cfg_data[BitSelW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: stage 1 moves on when the result register is free
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind  <= kind;
      s1_level <= trigger_level;
      s1_id    <= frame_id;
      s1_data  <= frame_data;
    end
  end

  wss_frame_match u_match (
    .cfg        (cfg),
    .frame_id   (s1_id),
    .frame_data (s1_data),
    .hit        (s1_hit)
  );

  assign s1_item.kind          = s1_kind;
  assign s1_item.trigger_level = s1_level;
  assign s1_item.frame_hit     = s1_hit;

  wss_seq_core #(
    .SHUTDOWN_TICKS (SHUTDOWN_TICKS),
    .CAN_HOLD_TICKS (CAN_HOLD_TICKS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (s1_adv),
    .item    (s1_item),
    .res     (res)
  );

  // Result register: load on advance, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      awake            <= res.awake;
      power_up_event   <= res.power_up_event;
      power_down_event <= res.power_down_event;
      flush_and_cut    <= res.flush_and_cut;
      output_level     <= res.output_level;
    end
  end

  // A flush always leaves the power output low
  assert property (@(posedge clk) disable iff (rst)
    out_valid && flush_and_cut |-> !output_level)
    else $error("flush without output cut");

  // A sleep event always leaves the system asleep
  assert property (@(posedge clk) disable iff (rst)
    out_valid && power_down_event |-> !awake)
    else $error("power-down event while awake");

  // A lone wake event leaves the system awake
  assert property (@(posedge clk) disable iff (rst)
    out_valid && power_up_event && !power_down_event |-> awake)
    else $error("power-up event while asleep");

  // With the result register empty the input side never stalls
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

// ===== bench/wake_sleep_power_sequencer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wake/sleep power sequencer testbench
// Drives tick and CAN frame beats through the sequencer under random sender
// bursts and receiver stalls. A local model of the wake, sleep, shutdown
// countdown and CAN hold logic predicts every status beat, which is checked
// field by field in order.
// ----------------------------------------------------------------------------
module wake_sleep_power_sequencer_test;
  import wss_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_PHASES    = 9;
  localparam int unsigned PHASE_ITEMS      = 200;

  localparam cfg_t RESET_CFG = '{1'b0, 1'b0, 1'b0, 11'h7FF, BIT_ANY};

  logic               clk;
  logic               rst           = 1'b1;
  logic               cfg_we        = 1'b0;
  logic [CfgIdxW-1:0] cfg_index     = REG_PIN_TRIGGER_EN;
  logic [CfgW-1:0]    cfg_data      = '0;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic               kind          = KIND_TICK;
  logic               trigger_level = 1'b0;
  logic [IdW-1:0]     frame_id      = '0;
  logic [DataW-1:0]   frame_data    = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic               awake;
  logic               power_up_event;
  logic               power_down_event;
  logic               flush_and_cut;
  logic               output_level;

  wake_sleep_power_sequencer dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .kind             (kind),
    .trigger_level    (trigger_level),
    .frame_id         (frame_id),
    .frame_data       (frame_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .awake            (awake),
    .power_up_event   (power_up_event),
    .power_down_event (power_down_event),
    .flush_and_cut    (flush_and_cut),
    .output_level     (output_level)
  );

  // Sequencer model state and its copy of the registers
  cfg_t              cur_cfg      = RESET_CFG;
  logic              sys_awake    = 1'b1;
  logic [CountW-1:0] shutdown_cnt = '0;
  logic [HoldW-1:0]  hold_cnt     = '0;
  logic              pin_powered  = 1'b1;
  logic              woke;
  logic              slept;

  res_t        expected_status_q[$];
  res_t        got_status;
  res_t        want_status;
  int unsigned err_count     = 0;
  int unsigned cycle_count   = 0;
  int unsigned burst_left    = 0;
  logic        tick_level    = 1'b1;
  bit          hold_off_req  = 1'b0;
  string       status_field[5] = '{"awake", "power_up_event", "power_down_event",
                                   "flush_and_cut", "output_level"};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------

  function automatic void enter_awake();
    if (!sys_awake) begin
      woke      = 1'b1;
      sys_awake = 1'b1;
      if (cur_cfg.output_enabled) pin_powered = 1'b1;
    end
  endfunction

  function automatic void enter_sleep();
    if (sys_awake) begin
      slept        = 1'b1;
      sys_awake    = 1'b0;
      shutdown_cnt = CountW'(DefShutdownTicks);
    end
  endfunction

  // Advance the model by one item and return the status it reports
  function automatic res_t next_status(input logic k, input logic lvl,
                                       input logic [IdW-1:0] id,
                                       input logic [DataW-1:0] d);
    res_t r;
    logic hit;
    r     = '0;
    woke  = 1'b0;
    slept = 1'b0;
    if (k == KIND_TICK) begin
      if (cur_cfg.pin_trigger_enabled) begin
        if (lvl) enter_awake();
        else enter_sleep();
      end
      if (shutdown_cnt != 0) begin
        shutdown_cnt = shutdown_cnt - 1'b1;
        if (shutdown_cnt == 0 && cur_cfg.output_enabled) begin
          r.flush_and_cut = 1'b1;
          pin_powered     = 1'b0;
        end
      end
      if (cur_cfg.can_listen_enabled) begin
        if (hold_cnt == 1) enter_sleep();
        if (hold_cnt != 0) hold_cnt = hold_cnt - 1'b1;
      end
    end else if (cur_cfg.can_listen_enabled && id == IdW'(cur_cfg.wake_frame_id)) begin
      if (cur_cfg.wake_bit_select == BIT_ANY) hit = 1'b1;
      else if (cur_cfg.wake_bit_select < DataW) hit = d[cur_cfg.wake_bit_select[5:0]];
      else hit = 1'b0;
      if (hit) begin
        enter_awake();
        hold_cnt = HoldW'(DefCanHoldTicks);
      end
    end
    r.awake            = sys_awake;
    r.power_up_event   = woke;
    r.power_down_event = slept;
    r.output_level     = pin_powered;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Drop valid and hold off for the length given by n
  task automatic idle_cycles(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Count down the current burst; open a gap when it runs out
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle_cycles($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(0, 12);
    end
  endtask

  // Offer one beat, wait for it to be taken, record its expected status
  task automatic send_item(input logic k, input logic lvl,
                           input logic [IdW-1:0] id, input logic [DataW-1:0] d);
    in_valid      <= 1'b1;
    kind          <= k;
    trigger_level <= lvl;
    frame_id      <= id;
    frame_data    <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_status_q.insert(expected_status_q.size(), next_status(k, lvl, id, d));
    pace();
  endtask

  // Wait until every status beat is back, then let the pipeline settle
  task automatic drain_results();
    idle_cycles(1);
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Pack one register's value, with random filler above its width
  function automatic logic [CfgW-1:0] reg_word(input reg_idx_t r, input cfg_t c);
    logic [CfgW-1:0] w;
    w = CfgW'($urandom);
    case (r)
      REG_PIN_TRIGGER_EN: w[0] = c.pin_trigger_enabled;
      REG_OUTPUT_EN:      w[0] = c.output_enabled;
      REG_CAN_LISTEN_EN:  w[0] = c.can_listen_enabled;
      REG_WAKE_FRAME_ID:  w = c.wake_frame_id;
      REG_WAKE_BIT_SEL:   w[BitSelW-1:0] = c.wake_bit_select;
      default:            w = '0;
    endcase
    return w;
  endfunction

  // Write every register, one per cycle; call only when idle
  task automatic write_config(input cfg_t c);
    reg_idx_t r;
    r = r.first();
    repeat (r.num()) begin
      cfg_we    <= 1'b1;
      cfg_index <= r;
      cfg_data  <= reg_word(r, c);
      @(posedge clk);
      r = r.next();
    end
    cfg_we  <= 1'b0;
    cur_cfg = c;
    @(posedge clk);
  endtask

  // Random beat: mostly ticks with a slowly changing pin, some frames aimed
  // at the wake identifier
  task automatic send_random_item(input int unsigned frame_pct);
    logic             k;
    logic [IdW-1:0]   id;
    logic [DataW-1:0] d;
    int unsigned      pick;
    k    = ($urandom_range(0, 99) < frame_pct) ? KIND_FRAME : KIND_TICK;
    d    = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    if (pick < 6) id = IdW'(cur_cfg.wake_frame_id);
    else if (pick < 8) id = IdW'(cur_cfg.wake_frame_id)
                            | (IdW'($urandom_range(1, 262143)) << WakeIdW);
    else id = IdW'($urandom);
    if ($urandom_range(0, 14) == 0) tick_level = ~tick_level;
    send_item(k, tick_level, id, d);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: stall pattern changes now and then; long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= mode_left[2];
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Check each status beat against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_status = {awake, power_up_event, power_down_event, flush_and_cut, output_level};
      if (expected_status_q.size() == 0) begin
        $display("%0t: unexpected status beat: expected none, actual %b",
                 $time, got_status);
        err_count++;
      end else begin
        want_status = expected_status_q.pop_front();
        for (int i = 0; i < 5; i++) begin
          if (want_status[4-i] !== got_status[4-i]) begin
            $display("%0t: %s mismatch: expected %b, actual %b", $time,
                     status_field[i], want_status[4-i], got_status[4-i]);
            err_count++;
          end
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("wake_sleep_power_sequencer_test NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults: pin and CAN disabled, so nothing changes
  task automatic test_defaults();
    send_item(KIND_TICK, 1'b0, '0, '0);
    send_item(KIND_TICK, 1'b1, '1, '1);
    send_item(KIND_FRAME, 1'b0, IdW'(11'h7FF), '1);
    send_item(KIND_FRAME, 1'b1, '1, '0);
  endtask

  // Pin sleep with countdown, CAN wake on top bit, flush, hold expiry and
  // wake plus sleep in the same tick
  task automatic test_pin_and_hold();
    logic [IdW-1:0] wid;
    wid = IdW'(11'h5A5);
    drain_results();
    write_config('{1'b1, 1'b1, 1'b1, 11'h5A5, 8'd63});
    send_item(KIND_TICK, 1'b0, '0, '0);
    send_item(KIND_TICK, 1'b0, '0, '0);
    send_item(KIND_FRAME, 1'b0, wid, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(KIND_FRAME, 1'b0, wid | (IdW'(1) << WakeIdW), '1);
    send_item(KIND_FRAME, 1'b0, wid, 64'h8000_0000_0000_0000);
    repeat (18) send_item(KIND_TICK, 1'b1, '0, '0);
    send_item(KIND_TICK, 1'b0, '0, '0);
    send_item(KIND_TICK, 1'b1, '0, '0);
  endtask

  // Bit settings: bit 0, out of range 64 and 254, and any frame
  task automatic test_bit_settings();
    drain_results();
    write_config('{1'b0, 1'b0, 1'b1, 11'd0, 8'd0});
    send_item(KIND_FRAME, 1'b0, '0, 64'hFFFF_FFFF_FFFF_FFFE);
    send_item(KIND_FRAME, 1'b0, '0, 64'h1);
    drain_results();
    write_config('{1'b0, 1'b0, 1'b1, 11'h7FF, 8'd64});
    send_item(KIND_FRAME, 1'b0, IdW'(11'h7FF), '1);
    drain_results();
    write_config('{1'b0, 1'b0, 1'b1, 11'h7FF, 8'd254});
    send_item(KIND_FRAME, 1'b0, IdW'(11'h7FF), '1);
    drain_results();
    write_config('{1'b0, 1'b0, 1'b1, 11'h7FF, BIT_ANY});
    send_item(KIND_FRAME, 1'b0, IdW'(11'h7FF), '0);
  endtask

  // Random traffic over several settings, extremes first
  task automatic test_random_traffic();
    cfg_t        c;
    int unsigned frame_pct;
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      c.pin_trigger_enabled = ($urandom_range(0, 3) != 0);
      c.output_enabled      = 1'($urandom_range(0, 1));
      c.can_listen_enabled  = ($urandom_range(0, 3) != 0);
      c.wake_frame_id       = WakeIdW'($urandom);
      case ($urandom_range(0, 5))
        0:       c.wake_bit_select = 8'd0;
        1:       c.wake_bit_select = 8'd63;
        2:       c.wake_bit_select = BitSelW'($urandom_range(64, 254));
        3:       c.wake_bit_select = BIT_ANY;
        default: c.wake_bit_select = BitSelW'($urandom_range(0, 63));
      endcase
      case (phase)
        0: c = '{1'b1, 1'b1, 1'b1, 11'h7FF, BIT_ANY};
        1: c = '{1'b1, 1'b0, 1'b1, 11'd0, 8'd0};
        2: c = '{1'b0, 1'b1, 1'b1, c.wake_frame_id, 8'd63};
        3: c = '{1'b1, 1'b1, 1'b0, c.wake_frame_id, 8'd254};
        default: ;
      endcase
      frame_pct = $urandom_range(3, 30);
      drain_results();
      write_config(c);
      repeat (PHASE_ITEMS) send_random_item(frame_pct);
    end
  endtask

  // Receiver holds off while the sender keeps offering beats back to back
  task automatic test_backpressure();
    drain_results();
    write_config('{1'b1, 1'b1, 1'b1, WakeIdW'($urandom), BIT_ANY});
    burst_left   = 1000;
    hold_off_req = 1'b1;
    repeat (60) send_random_item(20);
    burst_left = 0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_defaults();
    test_pin_and_hold();
    test_bit_settings();
    test_random_traffic();
    test_backpressure();
    drain_results();
    if (err_count == 0) begin
      $display("wake_sleep_power_sequencer_test OK");
    end else begin
      $display("wake_sleep_power_sequencer_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== wake_sleep_power_sequencer.f =====
sv/wss_pkg.sv
sv/wss_frame_match.sv
sv/wss_seq_core.sv
sv/wake_sleep_power_sequencer.sv
bench/wake_sleep_power_sequencer_test.sv
